// ----- sv/ccpc_pkg.sv -----
// ----------------------------------------------------------------------------
// ccpc_pkg
// Shared types and constants for the per-class confusion counter.
// ----------------------------------------------------------------------------
package ccpc_pkg;

    localparam int CODE_W  = 8;
    localparam int OUT_W   = 24;
    localparam int NUM_CLS = 4;
    localparam int NUM_KND = 4;
    localparam int NUM_CNT = NUM_CLS * NUM_KND;
    localparam int REG_W   = 3;
    localparam int CLS_W   = 2;
    localparam int KND_W   = 2;

    typedef logic [CODE_W-1:0] t_code;
    typedef logic [OUT_W-1:0]  t_count_out;
    typedef logic [REG_W-1:0]  t_reg_idx;
    typedef logic [CLS_W-1:0]  t_cls;
    typedef logic [KND_W-1:0]  t_kind;

    localparam t_reg_idx REG_SHADOW     = 3'd0;
    localparam t_reg_idx REG_PENUMBRA   = 3'd1;
    localparam t_reg_idx REG_OBJECT     = 3'd2;
    localparam t_reg_idx REG_BACKGROUND = 3'd3;
    localparam t_reg_idx REG_FILL       = 3'd4;
    localparam t_reg_idx REG_FOLD       = 3'd5;

    localparam t_cls CLS_SHADOW     = 2'd0;
    localparam t_cls CLS_OBJECT     = 2'd1;
    localparam t_cls CLS_BACKGROUND = 2'd2;
    localparam t_cls CLS_PENUMBRA   = 2'd3;
    localparam t_cls CLS_LAST       = CLS_PENUMBRA;

    localparam t_kind KND_TP = 2'd0;
    localparam t_kind KND_TN = 2'd1;
    localparam t_kind KND_FP = 2'd2;
    localparam t_kind KND_FN = 2'd3;

    localparam t_code RST_SHADOW     = 8'd0;
    localparam t_code RST_PENUMBRA   = 8'd153;
    localparam t_code RST_OBJECT     = 8'd255;
    localparam t_code RST_BACKGROUND = 8'd128;
    localparam t_code RST_FILL       = 8'd0;

endpackage

// ----- sv/ccpc_pix_if.sv -----
// ----------------------------------------------------------------------------
// ccpc_pix_if
// Pixel pair channel: predicted code, raw truth code and frame end marker.
// ----------------------------------------------------------------------------
interface ccpc_pix_if;
    logic            valid;
    logic            ready;
    ccpc_pkg::t_code predicted_pixel;
    ccpc_pkg::t_code truth_pixel;
    logic            frame_end;

    modport source (output valid, output predicted_pixel, output truth_pixel,
                    output frame_end, input ready);
    modport sink (input valid, input predicted_pixel, input truth_pixel,
                  input frame_end, output ready);
endinterface

// ----- sv/ccpc_rep_if.sv -----
// ----------------------------------------------------------------------------
// ccpc_rep_if
// Report channel: one beat per class with its four confusion counts.
// ----------------------------------------------------------------------------
interface ccpc_rep_if;
    logic                 valid;
    logic                 ready;
    ccpc_pkg::t_cls       class_index;
    ccpc_pkg::t_count_out true_pos;
    ccpc_pkg::t_count_out true_neg;
    ccpc_pkg::t_count_out false_pos;
    ccpc_pkg::t_count_out false_neg;
    logic                 report_last;

    modport source (output valid, output class_index, output true_pos,
                    output true_neg, output false_pos, output false_neg,
                    output report_last, input ready);
    modport sink (input valid, input class_index, input true_pos,
                  input true_neg, input false_pos, input false_neg,
                  input report_last, output ready);
endinterface

// ----- sv/confusion_count_per_class.sv -----
// A pixel is registered into stage one and counted from there; a frame end
// pixel loads the report buffer from stage one, which starts its report burst.
// Throughput: one pixel per cycle, but a frame end waits while the previous
// frame's report is still draining; each frame sends a burst of four beats.
// Reset clears the counters and loads the register defaults at once.
// ----------------------------------------------------------------------------
// confusion_count_per_class
// One-vs-rest confusion counters for four pixel classes, reported per frame.
// ----------------------------------------------------------------------------
module confusion_count_per_class #(
    parameter int COUNT_BITS = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    ccpc_pix_if.sink                 i_pix,
    ccpc_rep_if.source               o_rep,
    input  logic                     i_cfg_we,
    input  ccpc_pkg::t_reg_idx       i_cfg_index,
    input  logic [ccpc_pkg::CODE_W-1:0] i_cfg_data
);

    typedef logic [COUNT_BITS-1:0] t_cnt;

    ccpc_pkg::t_code r_shadow, r_penumbra, r_object, r_background, r_fill;
    logic            r_fold;

    logic            r_s1_valid;
    ccpc_pkg::t_code r_s1_pred;
    ccpc_pkg::t_code r_s1_truth;
    logic            r_s1_last;

    t_cnt r_cnt [ccpc_pkg::NUM_CNT];
    t_cnt n_cnt [ccpc_pkg::NUM_CNT];

    ccpc_pkg::t_count_out r_rep [ccpc_pkg::NUM_CNT];
    logic                 r_rep_busy;
    ccpc_pkg::t_cls       r_beat;

    ccpc_pkg::t_code cls_code [ccpc_pkg::NUM_CLS];
    ccpc_pkg::t_code truth;
    logic            known;
    logic            rep_fire;
    logic            rep_free;
    logic            s1_adv;
    logic            pix_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shadow     <= ccpc_pkg::RST_SHADOW;
            r_penumbra   <= ccpc_pkg::RST_PENUMBRA;
            r_object     <= ccpc_pkg::RST_OBJECT;
            r_background <= ccpc_pkg::RST_BACKGROUND;
            r_fill       <= ccpc_pkg::RST_FILL;
            r_fold       <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ccpc_pkg::REG_SHADOW:     r_shadow     <= i_cfg_data;
                ccpc_pkg::REG_PENUMBRA:   r_penumbra   <= i_cfg_data;
                ccpc_pkg::REG_OBJECT:     r_object     <= i_cfg_data;
                ccpc_pkg::REG_BACKGROUND: r_background <= i_cfg_data;
                ccpc_pkg::REG_FILL:       r_fill       <= i_cfg_data;
                ccpc_pkg::REG_FOLD:       r_fold       <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign rep_fire = o_rep.valid && o_rep.ready;
    assign rep_free = !r_rep_busy || (rep_fire && (r_beat == ccpc_pkg::CLS_LAST));
    assign s1_adv   = r_s1_valid && (!r_s1_last || rep_free);
    assign i_pix.ready = !r_s1_valid || s1_adv;
    assign pix_fire = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_s1_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_fire) begin
            r_s1_pred  <= i_pix.predicted_pixel;
            r_s1_truth <= i_pix.truth_pixel;
            r_s1_last  <= i_pix.frame_end;
        end
    end

    assign cls_code[ccpc_pkg::CLS_SHADOW]     = r_shadow;
    assign cls_code[ccpc_pkg::CLS_OBJECT]     = r_object;
    assign cls_code[ccpc_pkg::CLS_BACKGROUND] = r_background;
    assign cls_code[ccpc_pkg::CLS_PENUMBRA]   = r_penumbra;

    assign known = (r_s1_truth == r_shadow) || (r_s1_truth == r_object) ||
                   (r_s1_truth == r_background) || (r_s1_truth == r_penumbra);
    assign truth = (!known || (r_fold && (r_s1_truth == r_penumbra))) ?
                   r_fill : r_s1_truth;

    always_comb begin
        logic           p;
        logic           t;
        ccpc_pkg::t_kind kind;
        logic [ccpc_pkg::CLS_W+ccpc_pkg::KND_W-1:0] idx;
        for (int c = 0; c < ccpc_pkg::NUM_CLS; c++) begin
            p = (r_s1_pred == cls_code[c]);
            t = (truth == cls_code[c]);
            if (p) begin
                kind = t ? ccpc_pkg::KND_TP : ccpc_pkg::KND_FP;
            end else begin
                kind = t ? ccpc_pkg::KND_FN : ccpc_pkg::KND_TN;
            end
            for (int k = 0; k < ccpc_pkg::NUM_KND; k++) begin
                idx = {ccpc_pkg::CLS_W'(c), ccpc_pkg::KND_W'(k)};
                if ((kind == ccpc_pkg::KND_W'(k)) && !(&r_cnt[idx])) begin
                    n_cnt[idx] = r_cnt[idx] + t_cnt'(1);
                end else begin
                    n_cnt[idx] = r_cnt[idx];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ccpc_pkg::NUM_CNT; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (s1_adv) begin
            for (int i = 0; i < ccpc_pkg::NUM_CNT; i++) begin
                r_cnt[i] <= r_s1_last ? '0 : n_cnt[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_last) begin
            for (int i = 0; i < ccpc_pkg::NUM_CNT; i++) begin
                r_rep[i] <= ccpc_pkg::OUT_W'(32'(n_cnt[i]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep_busy <= 1'b0;
            r_beat     <= ccpc_pkg::CLS_SHADOW;
        end else if (s1_adv && r_s1_last) begin
            r_rep_busy <= 1'b1;
            r_beat     <= ccpc_pkg::CLS_SHADOW;
        end else if (rep_fire) begin
            r_rep_busy <= (r_beat != ccpc_pkg::CLS_LAST);
            r_beat     <= r_beat + ccpc_pkg::CLS_W'(1);
        end
    end

    assign o_rep.valid       = r_rep_busy;
    assign o_rep.class_index = r_beat;
    assign o_rep.true_pos    = r_rep[{r_beat, ccpc_pkg::KND_TP}];
    assign o_rep.true_neg    = r_rep[{r_beat, ccpc_pkg::KND_TN}];
    assign o_rep.false_pos   = r_rep[{r_beat, ccpc_pkg::KND_FP}];
    assign o_rep.false_neg   = r_rep[{r_beat, ccpc_pkg::KND_FN}];
    assign o_rep.report_last = (r_beat == ccpc_pkg::CLS_LAST);

    // A report buffer is only refilled once the previous burst has drained.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1_last) |-> (!r_rep_busy ||
            (rep_fire && (r_beat == ccpc_pkg::CLS_LAST))))
        else $error("report buffer overwritten before drained");

    a_clear_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1_last) |=> ((r_cnt[0] == '0) && (r_cnt[5] == '0) &&
            (r_cnt[15] == '0)))
        else $error("counters not cleared after frame end");

    a_burst_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rep.valid) |-> (r_beat == ccpc_pkg::CLS_SHADOW))
        else $error("report burst does not start with the first class");

    a_burst_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rep_fire && (r_beat != ccpc_pkg::CLS_LAST)) |=> o_rep.valid)
        else $error("report burst ended early");

endmodule
